// File: hdl/dsrm_pkg.sv
`default_nettype none

package dsrm_pkg;

  localparam int unsigned MaxTokens = 32;
  localparam int unsigned CountW    = $clog2(MaxTokens + 1);
  localparam int unsigned IdxW      = (MaxTokens > 1) ? $clog2(MaxTokens) : 1;

  localparam logic [7:0] ChStar = 8'h2A;
  localparam logic [7:0] ChDot  = 8'h2E;

  typedef enum logic [1:0] {
    OpPattern = 2'd0,
    OpText    = 2'd1,
    OpEnd     = 2'd2,
    OpClear   = 2'd3
  } op_e;

  // per-cell control from the sequencer
  typedef struct packed {
    logic used;      // token stored in this cell
    logic last;      // this position is the pattern end
    logic wr_byte;   // load a new unstarred token
    logic set_star;  // mark the stored token repeatable
    logic step;      // advance positions on a text byte
    logic restart;   // drop all positions
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: hdl/dot_star_regex_matcher.sv
`default_nettype none

// Whole-string matcher for patterns of literal bytes, '.' and '*'. Send pattern
// bytes (op 0), then text bytes (op 1), then an end request (op 2), which returns
// one result: matched, plus pattern_overflow if bytes beyond the 32-token capacity
// were dropped. Op 3 clears the pattern. Only end requests produce a result. One
// request is accepted per cycle; the output register lets the next request in while a
// result waits, and input stalls only while a result is held back by the consumer.
// Text bytes ripple through a row of 32 token cells, each holding one token and its
// active-position bit; the skip path for starred tokens runs combinationally the full
// length of that row.
module dot_star_regex_matcher
  import dsrm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] operation_i,
  input  wire logic [7:0] byte_value_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            matched_o,
  output logic            pattern_overflow_o
);

  op_e               op;
  logic              acc, acc_pat, acc_text, acc_end, acc_clear;
  logic [CountW-1:0] count_q, count_d;
  logic              ovf_q, ovf_d;
  logic              start_q, start_d;
  logic              act_end_q, act_end_d;
  logic              out_valid_q, out_valid_d;
  logic              matched_q, matched_d;
  logic              povf_q, povf_d;
  logic              full, is_star, star_ok, wr_new;
  logic [CountW-1:0] count_m1;

  cell_ctl_t           ctl   [MaxTokens];
  logic [MaxTokens:0]  skip_c;
  logic [MaxTokens:0]  hit_c;
  logic [MaxTokens-1:0] end_v;
  logic [MaxTokens-1:0] starred_v;
  logic                closed_end;

  assign op         = op_e'(operation_i);
  assign in_stall_o = out_valid_q & out_stall_i;
  assign acc        = in_valid_i & ~in_stall_o;
  assign acc_pat    = acc & (op == OpPattern);
  assign acc_text   = acc & (op == OpText);
  assign acc_end    = acc & (op == OpEnd);
  assign acc_clear  = acc & (op == OpClear);

  assign full     = (count_q == CountW'(MaxTokens));
  assign is_star  = (byte_value_i == ChStar);
  assign count_m1 = count_q - CountW'(1);
  assign star_ok  = is_star && (count_q != '0) && !starred_v[count_m1[IdxW-1:0]];
  assign wr_new   = acc_pat & ~star_ok & ~full;

  assign skip_c[0] = start_q;
  assign hit_c[0]  = 1'b0;

  for (genvar i = 0; i < MaxTokens; i++) begin : g_cell
    always_comb begin
      ctl[i].used     = count_q > CountW'(i);
      ctl[i].last     = count_q == CountW'(i);
      ctl[i].wr_byte  = wr_new & (count_q == CountW'(i));
      ctl[i].set_star = acc_pat & star_ok & (count_q == CountW'(i + 1));
      ctl[i].step     = acc_text;
      ctl[i].restart  = acc_end | acc_clear;
    end

    dsrm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl[i]),
      .byte_value_i(byte_value_i),
      .skip_i      (skip_c[i]),
      .hit_i       (hit_c[i]),
      .skip_o      (skip_c[i+1]),
      .hit_o       (hit_c[i+1]),
      .end_o       (end_v[i]),
      .starred_o   (starred_v[i])
    );
  end

  assign closed_end = act_end_q | skip_c[MaxTokens];

  always_comb begin
    count_d     = count_q;
    ovf_d       = ovf_q;
    start_d     = start_q;
    act_end_d   = act_end_q;
    out_valid_d = out_valid_q & out_stall_i;
    matched_d   = matched_q;
    povf_d      = povf_q;
    if (acc) begin
      unique case (op)
        OpPattern: begin
          if (wr_new) begin
            count_d = count_q + CountW'(1);
          end else if (!star_ok) begin
            ovf_d = 1'b1;
          end
        end
        OpText: begin
          start_d   = 1'b0;
          act_end_d = hit_c[MaxTokens];
        end
        OpEnd: begin
          out_valid_d = 1'b1;
          matched_d   = (|end_v) | (closed_end & full);
          povf_d      = ovf_q;
          start_d     = 1'b1;
          act_end_d   = 1'b0;
        end
        OpClear: begin
          count_d   = '0;
          ovf_d     = 1'b0;
          start_d   = 1'b1;
          act_end_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      start_q     <= 1'b1;
      act_end_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      start_q     <= start_d;
      act_end_q   <= act_end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    matched_q <= matched_d;
    povf_q    <= povf_d;
  end

  assign out_valid_o        = out_valid_q;
  assign matched_o          = matched_q;
  assign pattern_overflow_o = povf_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(MaxTokens))
    else $error("token count beyond capacity");

  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_end |=> out_valid_q)
    else $error("end request without result");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_clear |=> (count_q == '0) && !ovf_q && start_q)
    else $error("clear left pattern state");

  a_ovf_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovf_q) |-> $past(full))
    else $error("overflow flagged with free tokens");

endmodule

`default_nettype wire

// File: hdl/dsrm_cell.sv
`default_nettype none

module dsrm_cell
  import dsrm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cell_ctl_t  ctl_i,
  input  wire logic [7:0] byte_value_i,
  input  wire logic       skip_i,
  input  wire logic       hit_i,
  output logic            skip_o,
  output logic            hit_o,
  output logic            end_o,
  output logic            starred_o
);

  logic [7:0] tok_q;
  logic       star_q;
  logic       act_q, act_d;
  logic       closed, hit;

  assign closed    = act_q | skip_i;
  assign hit       = closed & ctl_i.used & ((tok_q == ChDot) | (tok_q == byte_value_i));
  assign skip_o    = closed & ctl_i.used & star_q;
  assign hit_o     = hit & ~star_q;
  assign end_o     = closed & ctl_i.last;
  assign starred_o = star_q;

  always_comb begin
    priority if (ctl_i.restart) begin
      act_d = 1'b0;
    end else if (ctl_i.step) begin
      act_d = (hit & star_q) | hit_i;
    end else begin
      act_d = act_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else begin
      act_q <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_byte) begin
      tok_q  <= byte_value_i;
      star_q <= 1'b0;
    end else if (ctl_i.set_star) begin
      star_q <= 1'b1;
    end
  end

endmodule

`default_nettype wire
